@@ src/h2r_pkg.sv @@
// Shared types, field widths, lane codes and the gamma table for the HSL to RGB converter.
`default_nettype none

package h2r_pkg;

  // Field widths of one pixel in and one pixel out
  localparam int HUE_W       = 9;
  localparam int SAT_W       = 8;
  localparam int LUM_W       = 8;
  localparam int CH_W        = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Extra shift of the reciprocal constants; keeps the divide-by-constant exact
  localparam int RECIP_SH = 18;

  // Hue offset applied by a channel lane
  typedef logic [1:0] shift_t;
  localparam shift_t SHIFT_NONE = 2'd0;
  localparam shift_t SHIFT_UP   = 2'd1;
  localparam shift_t SHIFT_DOWN = 2'd2;

  // Per-stage advance enables, stage 1 in the lowest bit
  typedef struct packed {
    logic s7;
    logic s6;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } stage_en_t;

  typedef logic [CH_W-1:0] chan_t;

  localparam chan_t GAMMA_LUT [256] = '{
      8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
      8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
      8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
      8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
      8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,
      8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
      8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd8,
      8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,
      8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,
      8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd12,  8'd12,  8'd13,
      8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd14,  8'd14,  8'd15,
      8'd15,  8'd15,  8'd16,  8'd16,  8'd16,  8'd16,  8'd17,  8'd17,
      8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd19,  8'd20,
      8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd22,  8'd23,
      8'd23,  8'd24,  8'd24,  8'd25,  8'd25,  8'd25,  8'd26,  8'd26,
      8'd27,  8'd27,  8'd28,  8'd28,  8'd29,  8'd29,  8'd30,  8'd30,
      8'd31,  8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd35,
      8'd36,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd40,
      8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
      8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
      8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
      8'd63,  8'd64,  8'd65,  8'd66,  8'd68,  8'd69,  8'd70,  8'd71,
      8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd81,  8'd82,
      8'd83,  8'd85,  8'd86,  8'd88,  8'd90,  8'd91,  8'd93,  8'd94,
      8'd96,  8'd98,  8'd99,  8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
      8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
      8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
      8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
      8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
      8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
      8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
  };

endpackage

`default_nettype wire

@@ src/h2r_front.sv @@
// Front end: normalize hue, saturation and lightness, then form m1 and m2 - m1.
`default_nettype none

module h2r_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  h2r_pkg::stage_en_t             en,
  input  logic [h2r_pkg::HUE_W-1:0]      hue_deg,
  input  logic [h2r_pkg::SAT_W-1:0]      saturation,
  input  logic [h2r_pkg::LUM_W-1:0]      lightness,
  output logic [FRAC_BITS:0]             nhue_s2,
  output logic signed [FRAC_BITS+2:0]    m1_s3,
  output logic signed [FRAC_BITS+2:0]    d_s3
);
  import h2r_pkg::*;

  localparam int NW = FRAC_BITS + 1;
  localparam int MW = FRAC_BITS + 3;
  localparam int PW = FRAC_BITS + RECIP_SH + HUE_W;
  localparam longint unsigned SCALE     = 64'd1 << (FRAC_BITS + RECIP_SH);
  localparam longint unsigned RECIP_360 = (SCALE + 64'd359) / 64'd360;
  localparam longint unsigned RECIP_255 = (SCALE + 64'd254) / 64'd255;

  // Stage 1: x * ONE / k as x times a rounded-up reciprocal
  logic [PW-1:0] hue_prod, sat_prod, lum_prod;
  logic [NW-1:0] nhue_r, nsat_r, nlum_r;
  logic          lhi_r;

  assign hue_prod = PW'(hue_deg) * PW'(RECIP_360);
  assign sat_prod = PW'(saturation) * PW'(RECIP_255);
  assign lum_prod = PW'(lightness) * PW'(RECIP_255);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      nhue_r <= hue_prod[RECIP_SH +: NW];
      nsat_r <= sat_prod[RECIP_SH +: NW];
      nlum_r <= lum_prod[RECIP_SH +: NW];
      lhi_r  <= lightness[LUM_W-1];
    end
  end

  // Stage 2: lightness times saturation
  logic [2*NW-1:0] ls_prod;
  logic [NW-1:0]   p_r, nsat_s2_r, nlum_s2_r, nhue_s2_r;
  logic            lhi_s2_r;

  assign ls_prod = nlum_r * nsat_r;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p_r       <= ls_prod[FRAC_BITS +: NW];
      nsat_s2_r <= nsat_r;
      nlum_s2_r <= nlum_r;
      nhue_s2_r <= nhue_r;
      lhi_s2_r  <= lhi_r;
    end
  end

  assign nhue_s2 = nhue_s2_r;

  // Stage 3: m2, m1 and the ramp span
  logic signed [MW-1:0] lum_x, sat_x, p_x, m2, m1_nxt, d_nxt;
  logic signed [MW-1:0] m1_r, d_r;

  always_comb begin
    lum_x  = $signed(MW'(nlum_s2_r));
    sat_x  = $signed(MW'(nsat_s2_r));
    p_x    = $signed(MW'(p_r));
    m2     = lhi_s2_r ? (lum_x + sat_x - p_x) : (lum_x + p_x);
    m1_nxt = (lum_x <<< 1) - m2;
    d_nxt  = m2 - m1_nxt;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      m1_r <= m1_nxt;
      d_r  <= d_nxt;
    end
  end

  assign m1_s3 = m1_r;
  assign d_s3  = d_r;

endmodule

`default_nettype wire

@@ src/h2r_lane.sv @@
// One color channel: hue wrap and ramp segment, ramp product, byte scaling.
`default_nettype none

module h2r_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  h2r_pkg::stage_en_t          en,
  input  h2r_pkg::shift_t             shift,
  input  logic [FRAC_BITS:0]          nhue,
  input  logic signed [FRAC_BITS+2:0] m1,
  input  logic signed [FRAC_BITS+2:0] d,
  output h2r_pkg::chan_t              chan
);
  import h2r_pkg::*;

  localparam int HW  = FRAC_BITS + 4;
  localparam int FW  = FRAC_BITS + 2;
  localparam int MW  = FRAC_BITS + 3;
  localparam int PRW = MW + FW;
  localparam int CW  = FRAC_BITS + 6;
  localparam int BW  = CW + 8;
  localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [HW-1:0] ONE        = HW'(ONE_L);
  localparam logic signed [HW-1:0] TWO_ONE    = HW'(2 * ONE_L);
  localparam logic signed [HW-1:0] THIRD      = HW'(ONE_L / 3);
  localparam logic signed [HW-1:0] TWO_THIRDS = HW'((2 * ONE_L) / 3);

  // Stage 3: wrap hue once, pick the ramp weight (ONE on the flat top, 0 on the floor)
  logic signed [HW-1:0] h, h6, tt, tt6;
  logic signed [FW-1:0] factor_nxt, factor_r;

  always_comb begin
    h = $signed(HW'(nhue));
    case (shift)
      SHIFT_UP:   h = h + THIRD;
      SHIFT_DOWN: h = h - THIRD;
      default:    ;
    endcase
    if (h < 0) h = h + ONE;
    if (h > ONE) h = h - ONE;
    h6  = (h <<< 2) + (h <<< 1);
    tt  = TWO_THIRDS - h;
    tt6 = (tt <<< 2) + (tt <<< 1);
    if (h6 < ONE) begin
      factor_nxt = FW'(h6);
    end else if ((h <<< 1) < ONE) begin
      factor_nxt = FW'(ONE);
    end else if ((h <<< 1) + h < TWO_ONE) begin
      factor_nxt = FW'(tt6);
    end else begin
      factor_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      factor_r <= factor_nxt;
    end
  end

  // Stage 4: span times weight
  logic signed [PRW-1:0] prod_nxt, prod_r;
  logic signed [MW-1:0]  m1_s4_r;

  assign prod_nxt = PRW'(d) * PRW'(factor_r);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      prod_r  <= prod_nxt;
      m1_s4_r <= m1;
    end
  end

  // Stage 5: scale down toward zero and add the floor
  logic signed [PRW-1:0] prod_neg, prod_sd;
  logic signed [CW-1:0]  ch_nxt, ch_r;

  always_comb begin
    prod_neg = -prod_r;
    prod_sd  = (prod_r < 0) ? -(prod_neg >>> FRAC_BITS) : (prod_r >>> FRAC_BITS);
    ch_nxt   = CW'(m1_s4_r) + CW'(prod_sd);
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      ch_r <= ch_nxt;
    end
  end

  // Stage 6: times 255, scale down toward zero, clamp to a byte
  logic signed [BW-1:0] w, w_neg, w_sd;
  chan_t                byte_nxt, byte_r;

  always_comb begin
    w     = (BW'(ch_r) <<< 8) - BW'(ch_r);
    w_neg = -w;
    w_sd  = (w < 0) ? -(w_neg >>> FRAC_BITS) : (w >>> FRAC_BITS);
    if (w_sd < 0) begin
      byte_nxt = '0;
    end else if (w_sd > 255) begin
      byte_nxt = '1;
    end else begin
      byte_nxt = w_sd[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s6) begin
      byte_r <= byte_nxt;
    end
  end

  assign chan = byte_r;

endmodule

`default_nettype wire

@@ src/hsl_to_rgb_converter.sv @@
// Top level of the HSL to RGB converter: stream handshake, stage control, gray path, gamma.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+-------------------------------------------
//   in_     | in  | in_tvalid / in_tready   | in_tdata: hue_deg, saturation, lightness
//   out_    | out | out_tvalid / out_tready | out_tdata: red, green, blue
//   cfg_    | in  | cfg_valid / cfg_ready   | cfg_data: gamma_enable
//
// Seven register stages; one beat enters per clock when the output side never stalls.
// Stage 1 normalizes by reciprocal multiply, stage 2 multiplies lightness by saturation,
// stage 3 forms m1/m2 and the three ramp weights, stage 4 runs the per-channel ramp
// multiply, stages 5-6 scale to a clamped byte, stage 7 applies gray and gamma and holds
// the output beat.
// Reset clears the stage valid bits and gamma_enable; payload registers are not reset.
// A stage holds while its successor is full and stalled; empty stages keep filling, so
// bubbles close up and nothing is dropped or repeated. cfg_ready is always high.
`default_nettype none

module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [8:0] hue_deg, [16:9] saturation, [24:17] lightness, [31:25] zero
  input  logic [h2r_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [h2r_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data
);
  import h2r_pkg::*;

  localparam int NSTG = 7;

  // Unpack the input beat
  logic [HUE_W-1:0] in_hue;
  logic [SAT_W-1:0] in_sat;
  logic [LUM_W-1:0] in_lum;

  assign in_hue = in_tdata[HUE_W-1:0];
  assign in_sat = in_tdata[HUE_W +: SAT_W];
  assign in_lum = in_tdata[HUE_W+SAT_W +: LUM_W];

  // Stage control: advance a stage when it is empty or its successor advances
  logic [NSTG-1:0] vld_r, vld_nxt, en_v;
  stage_en_t       en;

  always_comb begin
    en_v[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en_v[k] = !vld_r[k] || en_v[k+1];
    end
    vld_nxt[0] = en_v[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en_v[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign en = stage_en_t'(en_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = en_v[0];
  assign out_tvalid = vld_r[NSTG-1];

  // Configuration: gamma enable, written at any time
  logic gamma_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      gamma_en_r <= cfg_data;
    end
  end

  // Gray flag and lightness ride along stages 1 to 6
  logic             gray_r [NSTG-1];
  logic [LUM_W-1:0] lum_r  [NSTG-1];

  always_ff @(posedge clk) begin
    if (en_v[0]) begin
      gray_r[0] <= (in_sat == '0);
      lum_r[0]  <= in_lum;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (en_v[k]) begin
        gray_r[k] <= gray_r[k-1];
        lum_r[k]  <= lum_r[k-1];
      end
    end
  end

  // Shared front end and three channel lanes
  logic [FRAC_BITS:0]          nhue_s2;
  logic signed [FRAC_BITS+2:0] m1_s3, d_s3;
  chan_t                       red_s6, green_s6, blue_s6;

  h2r_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .en         (en),
    .hue_deg    (in_hue),
    .saturation (in_sat),
    .lightness  (in_lum),
    .nhue_s2    (nhue_s2),
    .m1_s3      (m1_s3),
    .d_s3       (d_s3)
  );

  h2r_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_red (
    .clk   (clk),
    .en    (en),
    .shift (SHIFT_UP),
    .nhue  (nhue_s2),
    .m1    (m1_s3),
    .d     (d_s3),
    .chan  (red_s6)
  );

  h2r_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_green (
    .clk   (clk),
    .en    (en),
    .shift (SHIFT_NONE),
    .nhue  (nhue_s2),
    .m1    (m1_s3),
    .d     (d_s3),
    .chan  (green_s6)
  );

  h2r_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_blue (
    .clk   (clk),
    .en    (en),
    .shift (SHIFT_DOWN),
    .nhue  (nhue_s2),
    .m1    (m1_s3),
    .d     (d_s3),
    .chan  (blue_s6)
  );

  // Stage 7: replace with lightness on gray, then optional gamma; hold as output beat
  chan_t red_sel, green_sel, blue_sel;
  chan_t red_nxt, green_nxt, blue_nxt;
  chan_t red_r, green_r, blue_r;

  always_comb begin
    red_sel   = gray_r[NSTG-2] ? lum_r[NSTG-2] : red_s6;
    green_sel = gray_r[NSTG-2] ? lum_r[NSTG-2] : green_s6;
    blue_sel  = gray_r[NSTG-2] ? lum_r[NSTG-2] : blue_s6;
    red_nxt   = gamma_en_r ? GAMMA_LUT[red_sel]   : red_sel;
    green_nxt = gamma_en_r ? GAMMA_LUT[green_sel] : green_sel;
    blue_nxt  = gamma_en_r ? GAMMA_LUT[blue_sel]  : blue_sel;
  end

  always_ff @(posedge clk) begin
    if (en_v[NSTG-1]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tdata = {blue_r, green_r, red_r};

  // Checks
  a_ready_when_unblocked: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled although the output side is not blocked");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
      (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted beat did not land in stage 1");

  a_last_stage_delivers: assert property (@(posedge clk) disable iff (!rst_n)
      (vld_r[NSTG-2] && en_v[NSTG-1]) |=> out_tvalid)
    else $error("beat advancing from stage 6 did not reach the output");

endmodule

`default_nettype wire
